### src/scm_pkg.sv
// Shared types, register codes and color math for the scalar-to-RGB colormap.
`timescale 1ns / 1ps
`default_nettype none
package scm_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int DIV_STAGES     = 4;
  localparam int STEPS_PER_STG  = FRAC_BITS / DIV_STAGES;

  localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd1;
  localparam logic [2:0] REG_COLOR_MODE = 3'd2;
  localparam logic [2:0] REG_REVERSE    = 3'd3;
  localparam logic [2:0] REG_ENTRIES    = 3'd4;

  typedef enum logic [1:0] {
    MODE_TABLE = 2'd0,
    MODE_JET   = 2'd1,
    MODE_GAMMA = 2'd2
  } color_mode_t;

  // item state that rides along the pipeline
  typedef struct packed {
    logic       cmd;
    logic       empty;
    logic       full;
    logic [7:0] ld_index;
    logic [23:0] ld_rgb;
  } item_t;

  // segment coefficients: a in Q.8, b integer
  typedef struct packed {
    logic signed [14:0] a;
    logic signed [12:0] b;
  } gamma_coef_t;

  function automatic gamma_coef_t gc(input int a, input int b);
    gamma_coef_t c;
    c.a = 15'(a);
    c.b = 13'(b);
    return c;
  endfunction

  function automatic logic below(input logic [16:0] x, input int k);
    return x < 17'(k * 256);
  endfunction

  function automatic gamma_coef_t gamma_red(input logic [16:0] x);
    gamma_coef_t c;
    if (below(x, 48))       c = gc(0, 0);
    else if (below(x, 65))  c = gc(1229, -226);
    else if (below(x, 79))  c = gc(-31, 89);
    else if (below(x, 98))  c = gc(1280, -316);
    else if (below(x, 109)) c = gc(1352, -343);
    else if (below(x, 110)) c = gc(5632, -2165);
    else if (below(x, 162)) c = gc(0, 255);
    else if (below(x, 174)) c = gc(-1971, 1503);
    else if (below(x, 192)) c = gc(1306, -725);
    else                    c = gc(0, 255);
    return c;
  endfunction

  function automatic gamma_coef_t gamma_green(input logic [16:0] x);
    gamma_coef_t c;
    if (below(x, 113))      c = gc(0, 0);
    else if (below(x, 145)) c = gc(1306, -575);
    else if (below(x, 176)) c = gc(0, 163);
    else if (below(x, 191)) c = gc(1574, -920);
    else                    c = gc(0, 255);
    return c;
  endfunction

  function automatic gamma_coef_t gamma_blue(input logic [16:0] x);
    gamma_coef_t c;
    if (below(x, 4))        c = gc(1280, 0);
    else if (below(x, 49))  c = gc(1331, 0);
    else if (below(x, 95))  c = gc(-1382, 519);
    else if (below(x, 128)) c = gc(0, 0);
    else if (below(x, 145)) c = gc(1254, -628);
    else if (below(x, 159)) c = gc(-1536, 953);
    else if (below(x, 176)) c = gc(0, 0);
    else                    c = gc(819, -563);
    return c;
  endfunction

  // a*x + b, rounded, saturated to 0..255
  function automatic logic [7:0] lin(input gamma_coef_t c, input logic [16:0] x);
    logic signed [35:0] s;
    logic signed [35:0] u;
    logic [7:0] r;
    s = 36'(c.a) * $signed(36'(x));
    s = s + (36'(c.b) <<< 16);
    if (s < 0) begin
      r = 8'd0;
    end else begin
      u = (s + 36'sd32768) >>> 16;
      r = (u > 36'sd255) ? 8'hFF : u[7:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/scm_div.sv
// Pipelined restoring divider producing a 16-bit fraction rem/div.
`timescale 1ns / 1ps
`default_nettype none
module scm_div #(
  parameter int DW  = 32,
  parameter int SBW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [DW-1:0]       in_rem,
  input  logic [DW-1:0]       in_div,
  input  logic [SBW-1:0]      in_side,
  output logic                in_take,
  output logic                out_valid,
  output logic [scm_pkg::FRAC_BITS-1:0] out_quo,
  output logic [SBW-1:0]      out_side,
  input  logic                out_take
);

  localparam int NST = scm_pkg::DIV_STAGES;
  localparam int SPS = scm_pkg::STEPS_PER_STG;
  localparam int QW  = scm_pkg::FRAC_BITS;

  logic [NST-1:0] v;
  logic [NST-1:0] take;
  logic [DW-1:0]  rem  [NST];
  logic [DW-1:0]  dv   [NST];
  logic [QW-1:0]  quo  [NST];
  logic [SBW-1:0] side [NST];

  genvar g;
  generate
    for (g = 0; g < NST; g++) begin : g_stage
      logic          src_v;
      logic [DW-1:0] src_rem;
      logic [DW-1:0] src_dv;
      logic [QW-1:0] src_quo;
      logic [SBW-1:0] src_side;
      logic [DW-1:0] rr;
      logic [QW-1:0] qq;
      logic [DW:0]   t;

      if (g == 0) begin : g_first
        assign src_v    = in_valid;
        assign src_rem  = in_rem;
        assign src_dv   = in_div;
        assign src_quo  = '0;
        assign src_side = in_side;
      end else begin : g_next
        assign src_v    = v[g-1];
        assign src_rem  = rem[g-1];
        assign src_dv   = dv[g-1];
        assign src_quo  = quo[g-1];
        assign src_side = side[g-1];
      end

      if (g == NST - 1) begin : g_last_take
        assign take[g] = !v[g] || out_take;
      end else begin : g_mid_take
        assign take[g] = !v[g] || take[g+1];
      end

      always_comb begin
        rr = src_rem;
        qq = src_quo;
        t  = '0;
        for (int k = 0; k < SPS; k++) begin
          t = {rr, 1'b0};
          if (t >= {1'b0, src_dv}) begin
            t  = t - {1'b0, src_dv};
            qq = {qq[QW-2:0], 1'b1};
          end else begin
            qq = {qq[QW-2:0], 1'b0};
          end
          rr = t[DW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[g] <= 1'b0;
        end else if (take[g]) begin
          v[g] <= src_v;
        end
      end

      always_ff @(posedge clk) begin
        if (take[g] && src_v) begin
          rem[g]  <= rr;
          dv[g]   <= src_dv;
          quo[g]  <= qq;
          side[g] <= src_side;
        end
      end
    end
  endgenerate

  assign in_take   = take[0];
  assign out_valid = v[NST-1];
  assign out_quo   = quo[NST-1];
  assign out_side  = side[NST-1];

endmodule
`default_nettype wire

### src/scm_color.sv
// Color stages: jet, Gamma-II and table lookup from the range fraction.
`timescale 1ns / 1ps
`default_nettype none
module scm_color #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [16:0]    in_frac,
  input  scm_pkg::item_t in_item,
  output logic           in_take,
  input  logic [1:0]     color_mode,
  input  logic           reverse_table,
  input  logic [8:0]     table_entries_used,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int NW = ((IW > 9) ? IW : 9) + 1;
  localparam int PW = IW + 17;

  logic [IW-1:0] nm1;
  logic [NW-1:0] tu_ext;

  always_comb begin
    tu_ext = NW'(table_entries_used);
    if (tu_ext == '0) begin
      nm1 = '0;
    end else if (tu_ext > NW'(TABLE_DEPTH)) begin
      nm1 = IW'(TABLE_DEPTH - 1);
    end else begin
      nm1 = IW'(tu_ext - NW'(1));
    end
  end

  logic take_a, take_b, take_c;

  // stage A: products and jet segment
  logic           va;
  scm_pkg::item_t ia;
  logic [PW-1:0]  tprod_a;
  logic [16:0]    gx_a;
  logic [16:0]    jarg_a;
  logic [1:0]     jseg_a;

  logic [18:0]    t4;
  logic [16:0]    jarg_n;
  logic [1:0]     jseg_n;
  logic [24:0]    gx_w;

  always_comb begin
    t4 = {in_frac, 2'b00};
    if (in_frac < 17'd16384) begin
      jseg_n = 2'd0;
      jarg_n = t4[16:0];
    end else if (in_frac < 17'd32768) begin
      jseg_n = 2'd1;
      jarg_n = 17'(19'd131072 - t4);
    end else if (in_frac < 17'd49152) begin
      jseg_n = 2'd2;
      jarg_n = 17'(t4 - 19'd131072);
    end else begin
      jseg_n = 2'd3;
      jarg_n = 17'(19'd262144 - t4);
    end
    gx_w = 25'(in_frac) * 25'd255 + 25'd128;
  end

  assign take_a = !va || take_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (take_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_a && in_valid) begin
      ia      <= in_item;
      tprod_a <= PW'(nm1) * PW'(in_frac);
      gx_a    <= gx_w[24:8];
      jarg_a  <= jarg_n;
      jseg_a  <= jseg_n;
    end
  end

  // stage B: jet color, gamma coefficients, table index
  logic                  vb;
  scm_pkg::item_t        ib;
  logic [23:0]           jet_b;
  logic [IW-1:0]         idx_b;
  scm_pkg::gamma_coef_t  gr_b, gg_b, gb_b;
  logic [16:0]           gx_b;

  logic [24:0]   jv_w;
  logic [7:0]    jv;
  logic [23:0]   jet_n;
  logic [PW:0]   tsum;
  logic [IW+1:0] qi;
  logic [IW-1:0] qc;
  logic [IW-1:0] idx_n;

  always_comb begin
    jv_w = 25'(jarg_a) * 25'd255 + 25'd32768;
    jv   = jv_w[23:16];
    case (jseg_a)
      2'd0:    jet_n = {8'd0, jv, 8'hFF};
      2'd1:    jet_n = {8'd0, 8'hFF, jv};
      2'd2:    jet_n = {jv, 8'hFF, 8'd0};
      default: jet_n = {8'hFF, jv, 8'd0};
    endcase
    tsum = (PW + 1)'(tprod_a) + (PW + 1)'(32768);
    qi   = tsum[PW:16];
    qc   = (qi > (IW + 2)'(nm1)) ? nm1 : qi[IW-1:0];
    idx_n = reverse_table ? (nm1 - qc) : qc;
  end

  assign take_b = !vb || take_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (take_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (take_b && va) begin
      ib    <= ia;
      jet_b <= jet_n;
      idx_b <= idx_n;
      gr_b  <= scm_pkg::gamma_red(gx_a);
      gg_b  <= scm_pkg::gamma_green(gx_a);
      gb_b  <= scm_pkg::gamma_blue(gx_a);
      gx_b  <= gx_a;
    end
  end

  // stage C: table read or write, gamma multiply-add
  logic        vc;
  logic        cmd_c;
  logic [23:0] jet_c;
  logic [23:0] gam_c;
  logic [23:0] rd_c;
  logic [23:0] mem [TABLE_DEPTH];

  logic          wr_ok;
  logic [IW-1:0] waddr;

  assign wr_ok = NW'(ib.ld_index) < NW'(TABLE_DEPTH);
  assign waddr = IW'(ib.ld_index);

  assign out_valid = vc && !cmd_c;
  assign take_c    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (take_c) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (take_c && vb) begin
      cmd_c <= ib.cmd;
      jet_c <= jet_b;
      gam_c <= {scm_pkg::lin(gr_b, gx_b), scm_pkg::lin(gg_b, gx_b),
                scm_pkg::lin(gb_b, gx_b)};
    end
  end

  // table writes land in item order with the reads
  always_ff @(posedge clk) begin
    if (take_c && vb) begin
      if (ib.cmd) begin
        if (wr_ok) begin
          mem[waddr] <= ib.ld_rgb;
        end
      end else begin
        rd_c <= mem[idx_b];
      end
    end
  end

  logic [23:0] color;

  always_comb begin
    case (color_mode)
      scm_pkg::MODE_TABLE: color = rd_c;
      scm_pkg::MODE_JET:   color = jet_c;
      scm_pkg::MODE_GAMMA: color = gam_c;
      default:             color = 24'hFFFFFF;
    endcase
  end

  assign red     = color[23:16];
  assign green   = color[15:8];
  assign blue    = color[7:0];
  assign in_take = take_a;

endmodule
`default_nettype wire

### src/scalar_to_rgb_colormap.sv
// Top level of the scalar-to-RGB colormap: config port, range clamp, divider, color stages.
`timescale 1ns / 1ps
`default_nettype none
// Maps one Q16.16 sample per clock to an 8-bit RGB color through a loaded
// table, the jet map or the Gamma-II map. An item passes through one clamp
// stage, four divider stages of four quotient bits each, and three color
// stages, the last of which holds the table RAM read. Throughput is one item
// per cycle; a stalled output backs up the pipeline stage by stage and empty
// stages keep filling. Load items (cmd 1) write the table in order with the
// map items around them and produce no result. Table entries are not cleared
// at reset and must be loaded before they are read. Config registers must be
// written only while the block is idle; the block does not enforce this.
module scalar_to_rgb_colormap #(
  parameter int TABLE_DEPTH  = 256,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    cmd,
  input  logic [SAMPLE_WIDTH-1:0] sample_value,
  input  logic [7:0]              entry_index,
  input  logic [7:0]              entry_red,
  input  logic [7:0]              entry_green,
  input  logic [7:0]              entry_blue,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int SBW = $bits(scm_pkg::item_t);

  logic signed [SW-1:0] range_low;
  logic signed [SW-1:0] range_high;
  logic [1:0]           color_mode;
  logic                 reverse_table;
  logic [8:0]           table_entries_used;

  logic wr_en;
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low          <= '0;
      range_high         <= SW'(65536);
      color_mode         <= scm_pkg::MODE_JET;
      reverse_table      <= 1'b0;
      table_entries_used <= 9'd256;
    end else if (wr_en) begin
      case (paddr[4:2])
        scm_pkg::REG_RANGE_LOW:  range_low          <= SW'($signed(pwdata));
        scm_pkg::REG_RANGE_HIGH: range_high         <= SW'($signed(pwdata));
        scm_pkg::REG_COLOR_MODE: color_mode         <= pwdata[1:0];
        scm_pkg::REG_REVERSE:    reverse_table      <= pwdata[0];
        scm_pkg::REG_ENTRIES:    table_entries_used <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      scm_pkg::REG_RANGE_LOW:  prdata = 32'(range_low);
      scm_pkg::REG_RANGE_HIGH: prdata = 32'(range_high);
      scm_pkg::REG_COLOR_MODE: prdata = {30'd0, color_mode};
      scm_pkg::REG_REVERSE:    prdata = {31'd0, reverse_table};
      scm_pkg::REG_ENTRIES:    prdata = {23'd0, table_entries_used};
      default:                 prdata = 32'd0;
    endcase
  end

  // clamp stage
  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sc;
  logic                 full_n;
  logic [SW-1:0]        rem_n;
  logic [SW-1:0]        div_n;
  scm_pkg::item_t       item_n;

  always_comb begin
    sx     = $signed(sample_value);
    full_n = sx >= range_high;
    if (sx < range_low) begin
      sc = range_low;
    end else if (full_n) begin
      sc = range_high;
    end else begin
      sc = sx;
    end
    // both differences fit SW bits unsigned once clamped
    rem_n = SW'(sc - range_low);
    div_n = SW'(range_high - range_low);
    item_n.cmd      = cmd;
    item_n.empty    = range_high <= range_low;
    item_n.full     = full_n;
    item_n.ld_index = entry_index;
    item_n.ld_rgb   = {entry_red, entry_green, entry_blue};
  end

  logic           v1;
  logic           take1;
  logic           div_take;
  logic [SW-1:0]  rem1;
  logic [SW-1:0]  div1;
  scm_pkg::item_t item1;

  assign take1    = !v1 || div_take;
  assign in_stall = !take1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (take1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take1 && in_valid) begin
      rem1  <= rem_n;
      div1  <= div_n;
      item1 <= item_n;
    end
  end

  logic                          dq_valid;
  logic [scm_pkg::FRAC_BITS-1:0] dq;
  logic [SBW-1:0]                dside;
  scm_pkg::item_t                ditem;
  logic                          color_take;
  logic [16:0]                   frac;

  scm_div #(
    .DW  (SW),
    .SBW (SBW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_rem    (rem1),
    .in_div    (div1),
    .in_side   (item1),
    .in_take   (div_take),
    .out_valid (dq_valid),
    .out_quo   (dq),
    .out_side  (dside),
    .out_take  (color_take)
  );

  assign ditem = dside;

  always_comb begin
    if (ditem.empty) begin
      frac = 17'd0;
    end else if (ditem.full) begin
      frac = 17'h10000;
    end else begin
      frac = {1'b0, dq};
    end
  end

  scm_color #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_color (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (dq_valid),
    .in_frac            (frac),
    .in_item            (ditem),
    .in_take            (color_take),
    .color_mode         (color_mode),
    .reverse_table      (reverse_table),
    .table_entries_used (table_entries_used),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .red                (red),
    .green              (green),
    .blue               (blue)
  );

endmodule
`default_nettype wire
